FILE: design/rv64_control_and_alu_decode_unit_assert.svh
// Assertion macros for the decode unit.
// ASSERT_CLK checks a property at each rising edge, with reset masking it.
// ASSERT_CLK_ALWAYS checks a property at every rising edge, reset included.
`ifndef RV64_CONTROL_AND_ALU_DECODE_UNIT_ASSERT_SVH
`define RV64_CONTROL_AND_ALU_DECODE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: design/rcad_pkg.sv
`timescale 1ns / 1ps
package rcad_pkg;

   localparam logic [6:0] OPC_CUSTOM_MUL = 7'b0000001;
   localparam logic [6:0] OPC_LOAD       = 7'b0000011;
   localparam logic [6:0] OPC_LOAD_FP    = 7'b0000111;
   localparam logic [6:0] OPC_OP_IMM     = 7'b0010011;
   localparam logic [6:0] OPC_AUIPC      = 7'b0010111;
   localparam logic [6:0] OPC_OP_IMM_32  = 7'b0011011;
   localparam logic [6:0] OPC_STORE      = 7'b0100011;
   localparam logic [6:0] OPC_STORE_FP   = 7'b0100111;
   localparam logic [6:0] OPC_OP         = 7'b0110011;
   localparam logic [6:0] OPC_LUI        = 7'b0110111;
   localparam logic [6:0] OPC_OP_32      = 7'b0111011;
   localparam logic [6:0] OPC_MADD       = 7'b1000011;
   localparam logic [6:0] OPC_OP_FP      = 7'b1010011;
   localparam logic [6:0] OPC_BRANCH     = 7'b1100011;
   localparam logic [6:0] OPC_JALR       = 7'b1100111;
   localparam logic [6:0] OPC_JAL        = 7'b1101111;

   localparam logic [6:0] F7_BASE   = 7'b0000000;
   localparam logic [6:0] F7_MULDIV = 7'b0000001;
   localparam logic [6:0] F7_ALT    = 7'b0100000;

   localparam logic [6:0] F7_FADD   = 7'b0000000;
   localparam logic [6:0] F7_FSUB   = 7'b0000100;
   localparam logic [6:0] F7_FMUL   = 7'b0001000;
   localparam logic [6:0] F7_FDIV   = 7'b0001100;
   localparam logic [6:0] F7_FSQRT  = 7'b0101100;
   localparam logic [6:0] F7_FCVT_I = 7'b1100000;
   localparam logic [6:0] F7_FCVT_F = 7'b1101000;
   localparam logic [6:0] F7_FSGNJ  = 7'b0010000;
   localparam logic [6:0] F7_FMINMX = 7'b0010100;
   localparam logic [6:0] F7_FCMP   = 7'b1010000;
   localparam logic [6:0] F7_FMV_WX = 7'b1111000;
   localparam logic [6:0] F7_FMV_XW = 7'b1110000;
   localparam logic [6:0] F7_FMADD  = 7'b1000011;
   localparam logic [6:0] F7_FMSUB  = 7'b1000111;
   localparam logic [6:0] F7_FNMADD = 7'b1001011;
   localparam logic [6:0] F7_FNMSUB = 7'b1001111;

   typedef enum logic [5:0] {
      ALU_NONE      = 6'd0,
      ALU_ADD       = 6'd1,
      ALU_SUB       = 6'd2,
      ALU_MUL       = 6'd3,
      ALU_SLL       = 6'd4,
      ALU_MULH      = 6'd5,
      ALU_SLT       = 6'd6,
      ALU_MULHSU    = 6'd7,
      ALU_SLTU      = 6'd8,
      ALU_MULHU     = 6'd9,
      ALU_XOR       = 6'd10,
      ALU_DIV       = 6'd11,
      ALU_SRL       = 6'd12,
      ALU_SRA       = 6'd13,
      ALU_DIVU      = 6'd14,
      ALU_OR        = 6'd15,
      ALU_REM       = 6'd16,
      ALU_AND       = 6'd17,
      ALU_REMU      = 6'd18,
      ALU_ADDW      = 6'd19,
      ALU_SLLW      = 6'd20,
      ALU_SRLW      = 6'd21,
      ALU_SRAW      = 6'd22,
      ALU_SUBW      = 6'd23,
      ALU_MULW      = 6'd24,
      ALU_DIVW      = 6'd25,
      ALU_DIVUW     = 6'd26,
      ALU_REMW      = 6'd27,
      ALU_REMUW     = 6'd28,
      ALU_FMADD_S   = 6'd29,
      ALU_FADD_S    = 6'd30,
      ALU_FSUB_S    = 6'd31,
      ALU_FMUL_S    = 6'd32,
      ALU_FDIV_S    = 6'd33,
      ALU_FSQRT_S   = 6'd34,
      ALU_FCVT_W_S  = 6'd35,
      ALU_FCVT_WU_S = 6'd36,
      ALU_FCVT_L_S  = 6'd37,
      ALU_FCVT_LU_S = 6'd38,
      ALU_FCVT_S_W  = 6'd39,
      ALU_FCVT_S_WU = 6'd40,
      ALU_FCVT_S_L  = 6'd41,
      ALU_FCVT_S_LU = 6'd42,
      ALU_FSGNJ_S   = 6'd43,
      ALU_FSGNJN_S  = 6'd44,
      ALU_FSGNJX_S  = 6'd45,
      ALU_FMIN_S    = 6'd46,
      ALU_FMAX_S    = 6'd47,
      ALU_FEQ_S     = 6'd48,
      ALU_FLT_S     = 6'd49,
      ALU_FLE_S     = 6'd50,
      ALU_FMV_W_X   = 6'd51,
      ALU_FMV_X_W   = 6'd52,
      ALU_FCLASS_S  = 6'd53,
      ALU_FMSUB_S   = 6'd54,
      ALU_FNMADD_S  = 6'd55,
      ALU_FNMSUB_S  = 6'd56
   } alu_op_type;

   typedef struct packed {
      logic alu_used;
      logic branch_flag;
      logic mem_write;
      logic mem_read;
      logic reg_write;
      logic mem_to_reg;
      logic alu_src_imm;
   } ctrl_flags_type;

   localparam ctrl_flags_type CTRL_NONE   = ctrl_flags_type'(7'h00);
   localparam ctrl_flags_type CTRL_REG    = ctrl_flags_type'(7'h44);
   localparam ctrl_flags_type CTRL_LOAD   = ctrl_flags_type'(7'h0F);
   localparam ctrl_flags_type CTRL_STORE  = ctrl_flags_type'(7'h51);
   localparam ctrl_flags_type CTRL_BRANCH = ctrl_flags_type'(7'h60);
   localparam ctrl_flags_type CTRL_IMM    = ctrl_flags_type'(7'h45);
   localparam ctrl_flags_type CTRL_JAL    = ctrl_flags_type'(7'h24);
   localparam ctrl_flags_type CTRL_JALR   = ctrl_flags_type'(7'h25);

endpackage

FILE: design/rcad_req_if.sv
`timescale 1ns / 1ps
interface rcad_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

FILE: design/rcad_rsp_if.sv
`timescale 1ns / 1ps
interface rcad_rsp_if;
   import rcad_pkg::*;

   logic       valid;
   logic       ready;
   logic       alu_src_imm;
   logic       mem_to_reg;
   logic       reg_write;
   logic       mem_read;
   logic       mem_write;
   logic       branch_flag;
   logic       alu_used;
   alu_op_type alu_operation;

   modport source (
      output valid, output alu_src_imm, output mem_to_reg, output reg_write,
      output mem_read, output mem_write, output branch_flag, output alu_used,
      output alu_operation, input ready
   );
   modport sink (
      input valid, input alu_src_imm, input mem_to_reg, input reg_write,
      input mem_read, input mem_write, input branch_flag, input alu_used,
      input alu_operation, output ready
   );
endinterface

FILE: design/rv64_control_and_alu_decode_unit.sv
`timescale 1ns / 1ps
// RV64 control and ALU decode. Each instruction beat is captured in an input
// register, decoded by the opcode/funct logic and held in the result register:
// a beat moves from the input register into the result register, and one
// beat is taken every cycle while the result side keeps up. The input
// register frees whenever the result register is empty or is being drained;
// a waiting result stalls the input register, and a full one refuses new beats.
module rv64_control_and_alu_decode_unit (
   input logic         clock,
   input logic         reset,
   rcad_req_if.sink    req_chan,
   rcad_rsp_if.source  rsp_chan
);
   import rcad_pkg::*;

`include "rv64_control_and_alu_decode_unit_assert.svh"

   logic           s1_valid_ff;
   logic           s1_valid_in;
   logic [31:0]    s1_instr_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   ctrl_flags_type rsp_flags_ff;
   alu_op_type     rsp_op_ff;

   logic           req_take;
   logic           s1_advance;
   logic [6:0]     opcode;
   logic [2:0]     funct3;
   logic [4:0]     funct5;
   logic [6:0]     funct7;
   ctrl_flags_type dec_flags;
   alu_op_type     dec_op;

   assign s1_advance     = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_instr_ff <= req_chan.instruction;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_flags_ff <= dec_flags;
         rsp_op_ff    <= dec_op;
      end
   end

   assign opcode = s1_instr_ff[6:0];
   assign funct3 = s1_instr_ff[14:12];
   assign funct5 = s1_instr_ff[24:20];
   assign funct7 = s1_instr_ff[31:25];

   always_comb begin
      unique case (opcode)
         OPC_OP:         dec_flags = CTRL_REG;
         OPC_LOAD:       dec_flags = CTRL_LOAD;
         OPC_STORE:      dec_flags = CTRL_STORE;
         OPC_BRANCH:     dec_flags = CTRL_BRANCH;
         OPC_OP_IMM:     dec_flags = CTRL_IMM;
         OPC_LUI:        dec_flags = CTRL_IMM;
         OPC_AUIPC:      dec_flags = CTRL_IMM;
         OPC_JAL:        dec_flags = CTRL_JAL;
         OPC_JALR:       dec_flags = CTRL_JALR;
         OPC_CUSTOM_MUL: dec_flags = CTRL_REG;
         OPC_LOAD_FP:    dec_flags = CTRL_LOAD;
         OPC_STORE_FP:   dec_flags = CTRL_STORE;
         OPC_OP_FP:      dec_flags = CTRL_REG;
         default:        dec_flags = CTRL_NONE;
      endcase
   end

   always_comb begin
      dec_op = ALU_NONE;
      unique case (opcode)
         OPC_OP: begin
            if (funct7 == F7_BASE) begin
               unique case (funct3)
                  3'd0:    dec_op = ALU_ADD;
                  3'd1:    dec_op = ALU_SLL;
                  3'd2:    dec_op = ALU_SLT;
                  3'd3:    dec_op = ALU_SLTU;
                  3'd4:    dec_op = ALU_XOR;
                  3'd5:    dec_op = ALU_SRL;
                  3'd6:    dec_op = ALU_OR;
                  default: dec_op = ALU_AND;
               endcase
            end else if (funct7 == F7_MULDIV) begin
               unique case (funct3)
                  3'd0:    dec_op = ALU_MUL;
                  3'd1:    dec_op = ALU_MULH;
                  3'd2:    dec_op = ALU_MULHSU;
                  3'd3:    dec_op = ALU_MULHU;
                  3'd4:    dec_op = ALU_DIV;
                  3'd5:    dec_op = ALU_DIVU;
                  3'd6:    dec_op = ALU_REM;
                  default: dec_op = ALU_REMU;
               endcase
            end else if (funct7 == F7_ALT && funct3 == 3'd0) begin
               dec_op = ALU_SUB;
            end else if (funct7 == F7_ALT && funct3 == 3'd5) begin
               dec_op = ALU_SRA;
            end
         end
         OPC_OP_IMM: begin
            unique case (funct3)
               3'd0: dec_op = ALU_ADD;
               3'd1: dec_op = ALU_SLL;
               3'd2: dec_op = ALU_SLT;
               3'd3: dec_op = ALU_SLTU;
               3'd4: dec_op = ALU_XOR;
               3'd5: begin
                  if (funct7 == F7_BASE) begin
                     dec_op = ALU_SRL;
                  end else if (funct7 == F7_ALT) begin
                     dec_op = ALU_SRA;
                  end
               end
               3'd6:    dec_op = ALU_OR;
               default: dec_op = ALU_AND;
            endcase
         end
         OPC_BRANCH: begin
            unique case (funct3)
               3'd0, 3'd1: dec_op = ALU_SUB;
               3'd4, 3'd5: dec_op = ALU_SLT;
               3'd6, 3'd7: dec_op = ALU_SLTU;
               default:    dec_op = ALU_NONE;
            endcase
         end
         OPC_LOAD, OPC_STORE, OPC_JALR, OPC_JAL, OPC_LUI, OPC_AUIPC: begin
            dec_op = ALU_ADD;
         end
         OPC_OP_IMM_32: begin
            if (funct3 == 3'd0) begin
               dec_op = ALU_ADDW;
            end else if (funct3 == 3'd1) begin
               dec_op = ALU_SLLW;
            end else if (funct3 == 3'd5 && funct7 == F7_BASE) begin
               dec_op = ALU_SRLW;
            end else if (funct3 == 3'd5 && funct7 == F7_ALT) begin
               dec_op = ALU_SRAW;
            end
         end
         OPC_OP_32: begin
            unique case (funct3)
               3'd0: begin
                  if (funct7 == F7_BASE) begin
                     dec_op = ALU_ADDW;
                  end else if (funct7 == F7_ALT) begin
                     dec_op = ALU_SUBW;
                  end else if (funct7 == F7_MULDIV) begin
                     dec_op = ALU_MULW;
                  end
               end
               3'd1: dec_op = ALU_SLLW;
               3'd4: dec_op = (funct7 == F7_MULDIV) ? ALU_DIVW : ALU_NONE;
               3'd5: begin
                  if (funct7 == F7_BASE) begin
                     dec_op = ALU_SRLW;
                  end else if (funct7 == F7_ALT) begin
                     dec_op = ALU_SRAW;
                  end else if (funct7 == F7_MULDIV) begin
                     dec_op = ALU_DIVUW;
                  end
               end
               3'd6:    dec_op = (funct7 == F7_MULDIV) ? ALU_REMW : ALU_NONE;
               3'd7:    dec_op = (funct7 == F7_MULDIV) ? ALU_REMUW : ALU_NONE;
               default: dec_op = ALU_NONE;
            endcase
         end
         OPC_MADD: dec_op = ALU_FMADD_S;
         OPC_OP_FP: begin
            unique case (funct7)
               F7_FADD:  dec_op = ALU_FADD_S;
               F7_FSUB:  dec_op = ALU_FSUB_S;
               F7_FMUL:  dec_op = ALU_FMUL_S;
               F7_FDIV:  dec_op = ALU_FDIV_S;
               F7_FSQRT: dec_op = ALU_FSQRT_S;
               F7_FCVT_I: begin
                  unique case (funct5)
                     5'd0:    dec_op = ALU_FCVT_W_S;
                     5'd1:    dec_op = ALU_FCVT_WU_S;
                     5'd2:    dec_op = ALU_FCVT_L_S;
                     5'd3:    dec_op = ALU_FCVT_LU_S;
                     default: dec_op = ALU_NONE;
                  endcase
               end
               F7_FCVT_F: begin
                  unique case (funct5)
                     5'd0:    dec_op = ALU_FCVT_S_W;
                     5'd1:    dec_op = ALU_FCVT_S_WU;
                     5'd2:    dec_op = ALU_FCVT_S_L;
                     5'd3:    dec_op = ALU_FCVT_S_LU;
                     default: dec_op = ALU_NONE;
                  endcase
               end
               F7_FSGNJ: begin
                  unique case (funct3)
                     3'd0:    dec_op = ALU_FSGNJ_S;
                     3'd1:    dec_op = ALU_FSGNJN_S;
                     3'd2:    dec_op = ALU_FSGNJX_S;
                     default: dec_op = ALU_NONE;
                  endcase
               end
               F7_FMINMX: begin
                  unique case (funct3)
                     3'd0:    dec_op = ALU_FMIN_S;
                     3'd1:    dec_op = ALU_FMAX_S;
                     default: dec_op = ALU_NONE;
                  endcase
               end
               F7_FCMP: begin
                  unique case (funct3)
                     3'd2:    dec_op = ALU_FEQ_S;
                     3'd1:    dec_op = ALU_FLT_S;
                     3'd0:    dec_op = ALU_FLE_S;
                     default: dec_op = ALU_NONE;
                  endcase
               end
               F7_FMV_WX: dec_op = ALU_FMV_W_X;
               F7_FMV_XW: begin
                  unique case (funct3)
                     3'd0:    dec_op = ALU_FMV_X_W;
                     3'd1:    dec_op = ALU_FCLASS_S;
                     default: dec_op = ALU_NONE;
                  endcase
               end
               F7_FMADD:  dec_op = ALU_FMADD_S;
               F7_FMSUB:  dec_op = ALU_FMSUB_S;
               F7_FNMADD: dec_op = ALU_FNMADD_S;
               F7_FNMSUB: dec_op = ALU_FNMSUB_S;
               default:   dec_op = ALU_NONE;
            endcase
         end
         OPC_LOAD_FP, OPC_STORE_FP: begin
            dec_op = (funct3 == 3'd2 || funct3 == 3'd3) ? ALU_ADD : ALU_NONE;
         end
         default: dec_op = ALU_NONE;
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.alu_src_imm   = rsp_flags_ff.alu_src_imm;
   assign rsp_chan.mem_to_reg    = rsp_flags_ff.mem_to_reg;
   assign rsp_chan.reg_write     = rsp_flags_ff.reg_write;
   assign rsp_chan.mem_read      = rsp_flags_ff.mem_read;
   assign rsp_chan.mem_write     = rsp_flags_ff.mem_write;
   assign rsp_chan.branch_flag   = rsp_flags_ff.branch_flag;
   assign rsp_chan.alu_used      = rsp_flags_ff.alu_used;
   assign rsp_chan.alu_operation = rsp_op_ff;

   `ASSERT_CLK(a_take_fills_s1, clock, reset, req_take |=> s1_valid_ff, "accepted beat lost")
   `ASSERT_CLK(a_s1_holds, clock, reset, (s1_valid_ff && !s1_advance) |=> $stable(s1_instr_ff), "stalled instruction changed")
   `ASSERT_CLK(a_s1_to_rsp, clock, reset, (s1_valid_ff && s1_advance) |=> rsp_valid_ff, "decoded beat dropped")
   `ASSERT_CLK(a_mem_uses_add, clock, reset, (rsp_valid_ff && (rsp_flags_ff.mem_read || rsp_flags_ff.mem_write)) |-> (rsp_op_ff == ALU_ADD || rsp_op_ff == ALU_NONE), "memory access without address add")

endmodule
